// File: design/msc_pkg.sv
// Package for the MIPS32 core: state machine states, opcodes, function codes, constants.
// Used by all modules of the design; depends on nothing.
package msc_pkg;

  localparam int DATA_INDEX_BITS = 16;
  localparam logic [31:0] HALT_PC = 32'hFFFF_FFFF;
  localparam logic [31:0] SP_RESET = 32'h0100_0000;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_COP = 6'h10;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDI = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI = 6'h0C;
  localparam logic [5:0] OP_ORI = 6'h0D;
  localparam logic [5:0] OP_LUI = 6'h0F;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SW = 6'h2B;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV = 6'h1A;
  localparam logic [5:0] FN_DIVU = 6'h1B;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_MEM,
    ST_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_instr;
    logic start_div;
    logic mem_access;
    logic write_back;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic is_div;
    logic halted_now;
  } status_t;

endpackage

// File: design/msc_divider.sv
// Iterative 32-bit divider, one quotient bit per cycle, signed and unsigned.
// Depends on msc_pkg; a divisor of zero yields a zero quotient.
module msc_divider
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_signed,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0] count;
  logic neg;
  logic zero_div;
  logic [32:0] trial;
  logic [31:0] rem_shift;

  assign rem_shift = {rem[30:0], quo[31]};
  assign trial = {1'b0, rem_shift} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 5'd1;
      if (count == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      zero_div <= (divisor == 32'd0);
      neg <= is_signed & (dividend[31] ^ divisor[31]);
      quo <= (is_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
      dvs <= (is_signed && divisor[31]) ? (32'd0 - divisor) : divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = zero_div ? 32'd0 : (neg ? (32'd0 - quo) : quo);

endmodule

// File: design/msc_datapath.sv
// Datapath of the MIPS32 core: register file, data memory, ALU, PC and counters.
// Depends on msc_pkg and msc_divider; driven by commands from msc_controller.
module msc_datapath
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [31:0] instruction_word,
  output logic [31:0] next_pc,
  output logic        halted,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [31:0] write_value,
  output logic [31:0] return_value,
  output logic [31:0] executed_count,
  output logic [31:0] rtype_count,
  output logic [31:0] itype_count,
  output logic [31:0] jtype_count,
  output logic [31:0] memory_access_count,
  output logic [31:0] branch_count
);

  logic [31:0] regs [32];
  logic [31:0] dmem [2**DATA_INDEX_BITS];
  logic [31:0] pc;
  logic [31:0] instr;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] alu;
  logic [31:0] mem_rd;
  logic [31:0] cnt_exec, cnt_r, cnt_i, cnt_j, cnt_mem, cnt_br;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] sext, zext;
  logic [31:0] addr;
  logic [31:0] div_q;
  logic [31:0] prod;

  logic [31:0] val;
  logic [4:0] dst;
  logic wr;
  logic [31:0] npc;
  logic [31:0] pc4;

  assign op = instr[31:26];
  assign rs = instr[25:21];
  assign rt = instr[20:16];
  assign rd = instr[15:11];
  assign sh = instr[10:6];
  assign fn = instr[5:0];
  assign imm = instr[15:0];
  assign sext = {{16{imm[15]}}, imm};
  assign zext = {16'd0, imm};
  assign addr = a + sext;
  assign pc4 = pc + 32'd4;
  assign prod = a * b;

  msc_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.start_div),
    .is_signed(fn == FN_DIV),
    .dividend(a),
    .divisor(b),
    .busy(status.div_busy),
    .quotient(div_q)
  );

  assign status.is_div = (op == OP_RTYPE) && (fn == FN_DIV || fn == FN_DIVU);
  assign status.halted_now = (pc == HALT_PC);

  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      instr <= {instruction_word[7:0], instruction_word[15:8],
                instruction_word[23:16], instruction_word[31:24]};
    end
    a <= regs[rs];
    b <= regs[rt];
  end

  always_ff @(posedge clk) begin
    if (op == OP_RTYPE) begin
      case (fn)
        FN_ADD, FN_ADDU: alu <= a + b;
        FN_SUB, FN_SUBU: alu <= a - b;
        FN_MULT, FN_MULTU: alu <= prod;
        FN_AND: alu <= a & b;
        FN_OR: alu <= a | b;
        FN_NOR: alu <= ~(a | b);
        FN_SLT: alu <= {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: alu <= {31'd0, a < b};
        FN_SLL: alu <= b << sh;
        FN_SRL: alu <= b >> sh;
        default: alu <= '0;
      endcase
    end else begin
      case (op)
        OP_ADDI, OP_ADDIU: alu <= a + sext;
        OP_SLTI: alu <= {31'd0, $signed(a) < $signed(sext)};
        OP_SLTIU: alu <= {31'd0, a < sext};
        OP_ANDI: alu <= a & zext;
        OP_ORI: alu <= a | zext;
        OP_LUI: alu <= {imm, 16'd0};
        OP_JAL: alu <= pc + 32'd8;
        default: alu <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_access) begin
      if (op == OP_SW) begin
        dmem[addr[DATA_INDEX_BITS-1:0]] <= b;
      end
      mem_rd <= dmem[addr[DATA_INDEX_BITS-1:0]];
    end
  end

  always_comb begin
    wr = 1'b0;
    dst = '0;
    val = alu;
    npc = pc4;
    if (op == OP_RTYPE) begin
      dst = rd;
      case (fn)
        FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_MULT, FN_MULTU, FN_AND, FN_OR,
        FN_NOR, FN_SLT, FN_SLTU, FN_SLL, FN_SRL: wr = 1'b1;
        FN_DIV, FN_DIVU: begin
          wr = 1'b1;
          val = div_q;
        end
        FN_JR: npc = a;
        default: wr = 1'b0;
      endcase
    end else if (op == OP_COP) begin
      wr = 1'b0;
    end else if (op == OP_J || op == OP_JAL) begin
      npc = {pc4[31:28], instr[25:0], 2'b00};
      wr = (op == OP_JAL);
      dst = 5'd31;
    end else begin
      dst = rt;
      case (op)
        OP_BEQ, OP_BNE: begin
          if ((a == b) == (op == OP_BEQ)) begin
            npc = pc4 + {sext[29:0], 2'b00};
          end
        end
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI: wr = 1'b1;
        OP_LW: begin
          wr = 1'b1;
          val = mem_rd;
        end
        default: wr = 1'b0;
      endcase
    end
    if (dst == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      dst = '0;
      val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        if (i == 29) begin
          regs[i] <= SP_RESET;
        end else if (i == 31) begin
          regs[i] <= HALT_PC;
        end else begin
          regs[i] <= '0;
        end
      end
    end else if (cmd.write_back && wr) begin
      regs[dst] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      cnt_exec <= '0;
      cnt_r <= '0;
      cnt_i <= '0;
      cnt_j <= '0;
      cnt_mem <= '0;
      cnt_br <= '0;
    end else if (cmd.write_back) begin
      pc <= npc;
      cnt_exec <= cnt_exec + 32'd1;
      if (op == OP_RTYPE || op == OP_COP) begin
        if (instr != 32'd0) begin
          cnt_r <= cnt_r + 32'd1;
        end
      end else if (op == OP_J || op == OP_JAL) begin
        cnt_j <= cnt_j + 32'd1;
      end else begin
        cnt_i <= cnt_i + 32'd1;
        if (op == OP_LW || op == OP_SW) begin
          cnt_mem <= cnt_mem + 32'd1;
        end
        if (op == OP_BEQ || op == OP_BNE) begin
          cnt_br <= cnt_br + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      write_enable <= wr;
      write_index <= dst;
      write_value <= val;
    end else if (cmd.load_out) begin
      write_enable <= 1'b0;
      write_index <= '0;
      write_value <= '0;
    end
  end

  assign next_pc = pc;
  assign halted = (pc == HALT_PC);
  assign return_value = regs[2];
  assign executed_count = cnt_exec;
  assign rtype_count = cnt_r;
  assign itype_count = cnt_i;
  assign jtype_count = cnt_j;
  assign memory_access_count = cnt_mem;
  assign branch_count = cnt_br;

endmodule

// File: design/msc_controller.sv
// Controller state machine of the MIPS32 core: sequences read, execute, divide, memory, writeback, output.
// Depends on msc_pkg; drives msc_datapath through cmd_t and reads status_t.
module msc_controller
  import msc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_instr = 1'b1;
          state_next = status.halted_now ? ST_WB : ST_READ;
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (status.is_div) begin
          cmd.start_div = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.mem_access = 1'b1;
          state_next = ST_MEM;
        end
      end
      ST_DIV: if (!status.div_busy) state_next = ST_MEM;
      ST_MEM: begin
        cmd.write_back = 1'b1;
        state_next = ST_OUT;
      end
      ST_WB: begin
        cmd.load_out = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/mips_single_cycle_core_top.sv
// MIPS32 core top level. An accepted item goes through the controller states READ, EXEC and
// MEM (DIV and DIVU also pass through DIV before MEM) to OUT, where its result is valid;
// once halted, an item goes from IDLE through WB to OUT. One item is in flight at a time: a
// new item is taken only in IDLE, and output stall holds the result in OUT. The
// synchronous reset clears the PC, counters and register file (sp and ra preset). Data memory
// is not cleared. Depends on msc_pkg, msc_controller and msc_datapath.
module mips_single_cycle_core_top
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic        halted,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic signed [31:0] write_value,
  output logic signed [31:0] return_value,
  output logic [31:0] executed_count,
  output logic [31:0] rtype_count,
  output logic [31:0] itype_count,
  output logic [31:0] jtype_count,
  output logic [31:0] memory_access_count,
  output logic [31:0] branch_count
);

  cmd_t cmd;
  status_t status;

  msc_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  msc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .instruction_word(instruction_word), .next_pc(next_pc), .halted(halted),
    .write_enable(write_enable), .write_index(write_index),
    .write_value(write_value), .return_value(return_value),
    .executed_count(executed_count), .rtype_count(rtype_count),
    .itype_count(itype_count), .jtype_count(jtype_count),
    .memory_access_count(memory_access_count), .branch_count(branch_count)
  );

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("Input taken while a result is pending.");
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> write_index != 5'd0)
    else $error("Write to register zero reported.");
  a_halt_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> halted == (next_pc == HALT_PC))
    else $error("Halt flag disagrees with PC.");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for mips_single_cycle_core_top: it feeds instruction items, predicts
// each retired result and compares every output field. Depends on msc_pkg and the core RTL.
module tb_top
  import msc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_UNUSED = 6'h3F;
  localparam logic [31:0] MEM_MASK = (32'd1 << DATA_INDEX_BITS) - 32'd1;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [31:0] return_value;
    logic [31:0] executed_count;
    logic [31:0] rtype_count;
    logic [31:0] itype_count;
    logic [31:0] jtype_count;
    logic [31:0] memory_access_count;
    logic [31:0] branch_count;
  } retire_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] instruction_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] next_pc;
  logic halted;
  logic write_enable;
  logic [4:0] write_index;
  logic signed [31:0] write_value;
  logic signed [31:0] return_value;
  logic [31:0] executed_count;
  logic [31:0] rtype_count;
  logic [31:0] itype_count;
  logic [31:0] jtype_count;
  logic [31:0] memory_access_count;
  logic [31:0] branch_count;

  mips_single_cycle_core_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0] pending_words[$];
  retire_t expected_retires[$];
  logic [15:0] stored_offsets[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;

  logic [31:0] regs[32];
  logic [31:0] mem[logic [31:0]];
  logic [31:0] pc;
  logic [31:0] cnt_exec, cnt_r, cnt_i, cnt_j, cnt_mem, cnt_br;

  function automatic logic [31:0] swap_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic push_word(logic [31:0] w);
    if (w[31:26] == OP_SW && w[25:21] == 5'd0) stored_offsets = {stored_offsets, w[15:0]};
    pending_words = {pending_words, swap_bytes(w)};
  endtask

  task automatic push_jr(logic [4:0] r);
    push_word(i_word(OP_ORI, 5'd0, r, {14'($urandom_range(16'h3FFF)), 2'b00}));
    push_word(r_word(FN_JR, r, 5'd0, 5'd0, 5'd0));
  endtask

  function automatic logic [31:0] random_wellformed();
    logic [5:0] r_ops[14] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_MULT, FN_MULTU, FN_DIV,
                             FN_DIVU, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU, FN_SLL};
    logic [5:0] i_ops[8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI,
                            OP_BEQ};
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    int unsigned pick;
    rs = 5'($urandom);
    rt = 5'($urandom);
    rd = 5'($urandom);
    imm = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 35)
      return r_word((pick < 3) ? FN_SRL : r_ops[$urandom_range(13)], rs, rt, rd,
                    5'($urandom));
    if (pick < 65) return i_word(i_ops[$urandom_range(7)], rs, rt, imm);
    if (pick < 72) return i_word(OP_BNE, rs, rt, imm);
    if (pick < 80) return i_word(OP_SW, 5'd0, rt, imm);
    if (pick < 90)
      return i_word(OP_LW, 5'd0, rt, stored_offsets[$urandom_range(stored_offsets.size() - 1)]);
    return {(pick < 95) ? OP_J : OP_JAL, 26'($urandom)};
  endfunction

  function automatic logic [31:0] random_noise();
    logic [31:0] w;
    w = $urandom;
    if (w[31:26] == OP_LW)
      w = i_word(OP_LW, 5'd0, w[20:16], stored_offsets[$urandom_range(stored_offsets.size() - 1)]);
    if (w[31:26] == OP_RTYPE && w[5:0] == FN_JR) w[5:0] = FN_UNUSED;
    return w;
  endfunction

  function automatic retire_t retire_instruction(logic [31:0] raw);
    retire_t res;
    logic [31:0] w, a, b, sext, val, npc;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh, dst;
    logic [15:0] imm;
    logic wr;
    wr = 1'b0;
    val = '0;
    dst = '0;
    npc = pc;
    if (pc != HALT_PC) begin
      w = swap_bytes(raw);
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sh = w[10:6];
      fn = w[5:0];
      imm = w[15:0];
      sext = {{16{imm[15]}}, imm};
      a = regs[rs];
      b = regs[rt];
      npc = pc + 32'd4;
      cnt_exec++;
      if (op == OP_RTYPE || op == OP_COP) begin
        if (w != 32'd0) cnt_r++;
        if (op == OP_RTYPE) begin
          wr = 1'b1;
          dst = rd;
          case (fn)
            FN_ADD, FN_ADDU: val = a + b;
            FN_SUB, FN_SUBU: val = a - b;
            FN_MULT, FN_MULTU: val = a * b;
            FN_DIV: begin
              if (b == 0) val = '0;
              else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) val = a;
              else val = $signed(a) / $signed(b);
            end
            FN_DIVU: val = (b == 0) ? '0 : a / b;
            FN_AND: val = a & b;
            FN_OR: val = a | b;
            FN_NOR: val = ~(a | b);
            FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            FN_SLL: val = b << sh;
            FN_SRL: val = b >> sh;
            FN_JR: begin
              wr = 1'b0;
              npc = a;
            end
            default: wr = 1'b0;
          endcase
        end
      end else if (op == OP_J || op == OP_JAL) begin
        cnt_j++;
        if (op == OP_JAL) begin
          wr = 1'b1;
          dst = 5'd31;
          val = pc + 32'd8;
        end
        npc = {npc[31:28], w[25:0], 2'b00};
      end else begin
        cnt_i++;
        wr = 1'b1;
        dst = rt;
        case (op)
          OP_BEQ, OP_BNE: begin
            cnt_br++;
            wr = 1'b0;
            if ((a == b) == (op == OP_BEQ)) npc = pc + 32'd4 + (sext << 2);
          end
          OP_ADDI, OP_ADDIU: val = a + sext;
          OP_SLTI: val = ($signed(a) < $signed(sext)) ? 32'd1 : 32'd0;
          OP_SLTIU: val = (a < sext) ? 32'd1 : 32'd0;
          OP_ANDI: val = a & {16'd0, imm};
          OP_ORI: val = a | {16'd0, imm};
          OP_LUI: val = {imm, 16'd0};
          OP_LW: begin
            cnt_mem++;
            val = mem.exists((a + sext) & MEM_MASK) ? mem[(a + sext) & MEM_MASK] : '0;
          end
          OP_SW: begin
            cnt_mem++;
            wr = 1'b0;
            mem[(a + sext) & MEM_MASK] = b;
          end
          default: wr = 1'b0;
        endcase
      end
      if (dst == 5'd0) wr = 1'b0;
      if (wr) regs[dst] = val;
      else begin
        dst = '0;
        val = '0;
      end
      pc = npc;
    end
    res.next_pc = npc;
    res.halted = (npc == HALT_PC);
    res.write_enable = wr;
    res.write_index = dst;
    res.write_value = val;
    res.return_value = regs[2];
    res.executed_count = cnt_exec;
    res.rtype_count = cnt_r;
    res.itype_count = cnt_i;
    res.jtype_count = cnt_j;
    res.memory_access_count = cnt_mem;
    res.branch_count = cnt_br;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %0t %s: got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic bit quiet_stretch();
    return items_sent >= 400 && items_sent < 600;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_retires = {expected_retires, retire_instruction(instruction_word)};
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 13)) begin
          in_valid <= 1'b1;
          instruction_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_retires.size() == 0) begin
          report_mismatch("unexpected result", next_pc, '0);
        end else begin
          retire_t e;
          e = expected_retires.pop_front();
          if (next_pc !== e.next_pc) report_mismatch("next_pc", next_pc, e.next_pc);
          if (halted !== e.halted) report_mismatch("halted", halted, e.halted);
          if (write_enable !== e.write_enable)
            report_mismatch("write_enable", write_enable, e.write_enable);
          if (write_index !== e.write_index)
            report_mismatch("write_index", write_index, e.write_index);
          if (write_value !== e.write_value)
            report_mismatch("write_value", write_value, e.write_value);
          if (return_value !== e.return_value)
            report_mismatch("return_value", return_value, e.return_value);
          if (executed_count !== e.executed_count)
            report_mismatch("executed_count", executed_count, e.executed_count);
          if (rtype_count !== e.rtype_count)
            report_mismatch("rtype_count", rtype_count, e.rtype_count);
          if (itype_count !== e.itype_count)
            report_mismatch("itype_count", itype_count, e.itype_count);
          if (jtype_count !== e.jtype_count)
            report_mismatch("jtype_count", jtype_count, e.jtype_count);
          if (memory_access_count !== e.memory_access_count)
            report_mismatch("memory_access_count", memory_access_count, e.memory_access_count);
          if (branch_count !== e.branch_count)
            report_mismatch("branch_count", branch_count, e.branch_count);
        end
      end
      out_stall <= !quiet_stretch() && $urandom_range(99) < 13;
    end
  end

  initial begin
    foreach (regs[i]) regs[i] = '0;
    regs[29] = SP_RESET;
    regs[31] = HALT_PC;
    pc = '0;
    {cnt_exec, cnt_r, cnt_i, cnt_j, cnt_mem, cnt_br} = '0;

    push_word(i_word(OP_ORI, 5'd0, 5'd1, 16'hFFFF));
    push_word(i_word(OP_LUI, 5'd0, 5'd2, 16'h8000));
    push_word(i_word(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF));
    push_word(r_word(FN_ADD, 5'd2, 5'd2, 5'd4, 5'd0));
    push_word(r_word(FN_DIV, 5'd2, 5'd3, 5'd5, 5'd0));
    push_word(r_word(FN_DIV, 5'd1, 5'd0, 5'd6, 5'd0));
    push_word(r_word(FN_DIVU, 5'd3, 5'd1, 5'd7, 5'd0));
    push_word(r_word(FN_MULT, 5'd3, 5'd2, 5'd8, 5'd0));
    push_word(r_word(FN_SUB, 5'd2, 5'd1, 5'd9, 5'd0));
    push_word(r_word(FN_NOR, 5'd1, 5'd2, 5'd10, 5'd0));
    push_word(r_word(FN_SLT, 5'd2, 5'd1, 5'd11, 5'd0));
    push_word(r_word(FN_SLTU, 5'd2, 5'd1, 5'd12, 5'd0));
    push_word(r_word(FN_SLL, 5'd0, 5'd3, 5'd13, 5'd31));
    push_word(r_word(FN_SRL, 5'd0, 5'd3, 5'd14, 5'd31));
    push_word(r_word(FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0));
    push_word(32'd0);
    push_word({OP_COP, 26'h3FF_FFFF});
    push_word(r_word(FN_UNUSED, 5'd1, 5'd2, 5'd15, 5'd0));
    push_word({OP_UNUSED, 26'h155_5555});
    push_word(i_word(OP_SW, 5'd0, 5'd2, 16'h8000));
    push_word(i_word(OP_LW, 5'd0, 5'd16, 16'h8000));
    push_word(i_word(OP_SLTI, 5'd3, 5'd17, 16'h8000));
    push_word(i_word(OP_SLTIU, 5'd1, 5'd18, 16'hFFFF));
    push_word(i_word(OP_BEQ, 5'd1, 5'd1, 16'h8000));
    push_word(i_word(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
    push_word({OP_JAL, 26'h3FF_FFFF});
    push_jr(5'd19);

    repeat (1000) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 3) push_jr(5'($urandom));
        else push_word(random_wellformed());
      end else begin
        push_word(random_noise());
      end
    end

    push_word(i_word(OP_ADDIU, 5'd0, 5'd20, 16'hFFFF));
    push_word(r_word(FN_JR, 5'd20, 5'd0, 5'd0, 5'd0));
    push_word(random_noise());
    push_word(random_noise());

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_retires.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_retires.size() == 0)
      $display("mips_single_cycle_core_top verification clean");
    else
      $display("mips_single_cycle_core_top verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("mips_single_cycle_core_top verification failed");
    $finish;
  end

endmodule
